/* hdl/tal_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tal_pkg
// Shared types and constants of the trochoid arc limit calculator.
// ----------------------------------------------------------------------------
package tal_pkg;

	localparam int TAL_DEPTH = 82;

	localparam logic [16:0] ACCEL_RESET    = 17'd5000;
	localparam logic [23:0] RADIUS_MAX     = 24'hFFFFFF;
	localparam logic [23:0] RADIUS_FLOOR   = 24'd500;
	localparam logic [16:0] RATIO_ONE      = 17'd65536;
	localparam logic [16:0] RATIO_DEFAULT  = 17'd39321;
	localparam logic [36:0] DEN_NO_FEED    = 37'd1000000000;
	localparam logic [31:0] RECIP_FIVE     = 32'hCCCCCCCD;

	// side data carried along the minimum radius divider
	typedef struct packed {
		logic [23:0] tool;
		logic [23:0] rmax;
		logic [21:0] den1;
		logic [36:0] den2;
		logic        fnz;
		logic        a0;
		logic        sat;
	} tal_pd_t;

	// side data carried along the ratio divider and square root
	typedef struct packed {
		logic [23:0] rmin;
		logic [23:0] rmax;
		logic [23:0] rec;
		logic        a0;
		logic        one;
	} tal_rt_t;

	typedef struct packed {
		logic [16:0] corner_ratio;
		logic [23:0] recommended_radius;
		logic [23:0] max_radius;
		logic [23:0] min_radius;
	} tal_res_t;

endpackage
`default_nettype wire

/* hdl/tal_out_buf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tal_out_buf
// Output register plus one skid entry, so the pipeline keeps taking items
// while a result waits.
// ----------------------------------------------------------------------------
module tal_out_buf (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  wire tal_pkg::tal_res_t in_res,
	output logic             out_valid,
	input  wire              out_ready,
	output tal_pkg::tal_res_t out_res
);

	logic              skid_v_q;
	tal_pkg::tal_res_t skid_q;
	logic              pop;
	logic              push;

	assign in_ready = !skid_v_q;
	assign pop      = out_valid && out_ready;
	assign push     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_v_q  <= 1'b0;
		end else if (!out_valid || pop) begin
			out_valid <= skid_v_q || push;
			skid_v_q  <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid || pop) begin
			out_res <= skid_v_q ? skid_q : in_res;
		end else if (push) begin
			skid_q <= in_res;
		end
	end

endmodule
`default_nettype wire

/* hdl/trochoid_arc_limit_calc.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trochoid_arc_limit_calc
// Minimum, maximum and recommended trochoid loop radius and corner ratio.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel (tdata: feed_rate, tool_diameter,
// loop_radius_factor, max_engagement) and leave on m_axis (tdata:
// min_radius, max_radius, recommended_radius, corner_ratio), one result
// per item, in order.
// The user must write the acceleration limit through cfg_we / cfg_wdata while
// the block is idle; the block does not enforce this. It resets to 5000 mm/s^2.
// Throughput is one item per cycle while the pipeline is not frozen by a
// stalled output. There are 83 register stages: 2 product stages, a
// 25-stage restoring divider for v^2/a (range check plus 24 quotient bits),
// 5 radius stages, a 33-stage fraction divider, a 16-stage square root, the
// result register and the output register.
// Reset clears all valid bits and the output buffer.
// When m_axis_tready is low the output register holds its item and one more
// item drops into a skid entry; only then does s_axis_tready fall and the
// whole pipeline freeze, losing nothing.
// ----------------------------------------------------------------------------
module trochoid_arc_limit_calc (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [16:0] cfg_wdata,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// feed_rate[16:0], tool_diameter[33:17], loop_radius_factor[49:34],
	// max_engagement[65:50], zero fill
	input  wire  [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// min_radius[23:0], max_radius[47:24], recommended_radius[71:48],
	// corner_ratio[88:72], zero fill
	output logic [95:0] m_axis_tdata
);

	logic [16:0] accel_q;
	logic        en;
	logic [tal_pkg::TAL_DEPTH-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q <= tal_pkg::ACCEL_RESET;
		end else if (cfg_we) begin
			accel_q <= cfg_wdata;
		end
	end

	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[tal_pkg::TAL_DEPTH-2:0], s_axis_tvalid};
		end
	end

	// stage 1: products
	logic [16:0] f_s1;
	logic [33:0] f2_s1;
	logic [32:0] lfd_s1;
	logic [32:0] med_s1;
	logic [33:0] f2_c;
	logic [32:0] lfd_c;
	logic [32:0] med_c;

	assign f2_c  = s_axis_tdata[16:0] * s_axis_tdata[16:0];
	assign lfd_c = s_axis_tdata[49:34] * s_axis_tdata[33:17];
	assign med_c = s_axis_tdata[65:50] * s_axis_tdata[33:17];

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1   <= s_axis_tdata[16:0];
			f2_s1  <= f2_c;
			lfd_s1 <= lfd_c;
			med_s1 <= med_c;
		end
	end

	// stage 2: scaling and tool radii
	logic [36:0] num_s2;
	logic [21:0] den1_s2;
	logic [36:0] den2_s2;
	logic [23:0] tool_s2;
	logic [23:0] rmax_s2;
	logic        fnz_s2;
	logic        a0_s2;
	logic [36:0] num_c;
	logic [34:0] med3_c;

	assign num_c  = ({3'b0, f2_s1} << 2) + {3'b0, f2_s1};
	assign med3_c = ({2'b0, med_s1} << 1) + {2'b0, med_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2  <= num_c;
			den1_s2 <= ({5'b0, accel_q} << 4) + ({5'b0, accel_q} << 1);
			den2_s2 <= (f_s1 != 17'd0) ? num_c : tal_pkg::DEN_NO_FEED;
			// both radii stay below 2^21, so they never reach saturation
			tool_s2 <= {5'b0, lfd_s1[32:14]};
			rmax_s2 <= {3'b0, med3_c[34:14]};
			fnz_s2  <= (f_s1 != 17'd0);
			a0_s2   <= (accel_q == 17'd0);
		end
	end

	// stage 3 and 24 divider stages: v^2/a, 24-bit quotient
	logic [36:0]      pd_rem_s  [0:24];
	logic [23:0]      pd_q_s    [0:24];
	tal_pkg::tal_pd_t pd_side_s [0:24];

	always_ff @(posedge clk) begin
		if (en) begin
			pd_rem_s[0]       <= num_s2;
			pd_q_s[0]         <= '0;
			pd_side_s[0].tool <= tool_s2;
			pd_side_s[0].rmax <= rmax_s2;
			pd_side_s[0].den1 <= den1_s2;
			pd_side_s[0].den2 <= den2_s2;
			pd_side_s[0].fnz  <= fnz_s2;
			pd_side_s[0].a0   <= a0_s2;
			pd_side_s[0].sat  <= {9'b0, num_s2} >= {den1_s2, 24'b0};
		end
	end

	for (genvar j = 0; j < 24; j++) begin : g_pdiv
		logic [45:0] trial;
		logic        ge;
		assign trial = {24'b0, pd_side_s[j].den1} << (23 - j);
		assign ge    = {9'b0, pd_rem_s[j]} >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				pd_rem_s[j+1]  <= ge ? pd_rem_s[j] - trial[36:0] : pd_rem_s[j];
				pd_q_s[j+1]    <= {pd_q_s[j][22:0], ge};
				pd_side_s[j+1] <= pd_side_s[j];
			end
		end
	end

	// radius stages
	logic [23:0] phys_c;
	logic [23:0] big_c;
	logic [23:0] rmin_r1;
	logic [23:0] rmax_r1;
	logic [36:0] den2_r1;
	logic        fnz_r1;
	logic        a0_r1;

	always_comb begin
		if (pd_side_s[24].a0) begin
			phys_c = '0;
		end else if (pd_side_s[24].sat) begin
			phys_c = tal_pkg::RADIUS_MAX;
		end else begin
			phys_c = pd_q_s[24];
		end
		big_c = (phys_c > pd_side_s[24].tool) ? phys_c : pd_side_s[24].tool;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rmin_r1 <= (big_c < tal_pkg::RADIUS_FLOOR) ? tal_pkg::RADIUS_FLOOR : big_c;
			rmax_r1 <= pd_side_s[24].rmax;
			den2_r1 <= pd_side_s[24].den2;
			fnz_r1  <= pd_side_s[24].fnz;
			a0_r1   <= pd_side_s[24].a0;
		end
	end

	// 13*min + 7*max, then /4 here and /5 by reciprocal next
	logic [28:0] mix_c;
	logic [26:0] y_r2;
	logic [23:0] rmin_r2;
	logic [23:0] rmax_r2;
	logic [36:0] den2_r2;
	logic        fnz_r2;
	logic        a0_r2;

	assign mix_c = ({5'b0, rmin_r1} << 3) + ({5'b0, rmin_r1} << 2) + {5'b0, rmin_r1}
		+ ({5'b0, rmax_r1} << 3) - {5'b0, rmax_r1};

	always_ff @(posedge clk) begin
		if (en) begin
			y_r2    <= mix_c[28:2];
			rmin_r2 <= rmin_r1;
			rmax_r2 <= rmax_r1;
			den2_r2 <= den2_r1;
			fnz_r2  <= fnz_r1;
			a0_r2   <= a0_r1;
		end
	end

	logic [58:0] y5_c;
	logic [23:0] rec_r3;
	logic [23:0] rmin_r3;
	logic [23:0] rmax_r3;
	logic [36:0] den2_r3;
	logic        fnz_r3;
	logic        a0_r3;

	assign y5_c = y_r2 * tal_pkg::RECIP_FIVE;

	always_ff @(posedge clk) begin
		if (en) begin
			rec_r3  <= y5_c[57:34];
			rmin_r3 <= rmin_r2;
			rmax_r3 <= rmax_r2;
			den2_r3 <= den2_r2;
			fnz_r3  <= fnz_r2;
			a0_r3   <= a0_r2;
		end
	end

	// a*r, then the 18x scale for the fed case
	logic [40:0] ar_c;
	logic [40:0] ar_r4;
	logic [23:0] rec_r4;
	logic [23:0] rmin_r4;
	logic [23:0] rmax_r4;
	logic [36:0] den2_r4;
	logic        fnz_r4;
	logic        a0_r4;

	assign ar_c = accel_q * rec_r3;

	always_ff @(posedge clk) begin
		if (en) begin
			ar_r4   <= ar_c;
			rec_r4  <= rec_r3;
			rmin_r4 <= rmin_r3;
			rmax_r4 <= rmax_r3;
			den2_r4 <= den2_r3;
			fnz_r4  <= fnz_r3;
			a0_r4   <= a0_r3;
		end
	end

	logic [45:0] num2_r5;
	logic [23:0] rec_r5;
	logic [23:0] rmin_r5;
	logic [23:0] rmax_r5;
	logic [36:0] den2_r5;
	logic        a0_r5;

	always_ff @(posedge clk) begin
		if (en) begin
			num2_r5 <= fnz_r4 ? ({5'b0, ar_r4} << 4) + ({5'b0, ar_r4} << 1)
				: {5'b0, ar_r4};
			rec_r5  <= rec_r4;
			rmin_r5 <= rmin_r4;
			rmax_r5 <= rmax_r4;
			den2_r5 <= den2_r4;
			a0_r5   <= a0_r4;
		end
	end

	// fraction divider: floor(num * 2^32 / den), one bit a stage
	logic [36:0]      fr_rem_s  [0:32];
	logic [36:0]      fr_den_s  [0:32];
	logic [31:0]      fr_q_s    [0:32];
	tal_pkg::tal_rt_t fr_side_s [0:32];
	logic             one_c;

	assign one_c = num2_r5 >= {9'b0, den2_r5};

	always_ff @(posedge clk) begin
		if (en) begin
			fr_rem_s[0]       <= one_c ? '0 : num2_r5[36:0];
			fr_den_s[0]       <= den2_r5;
			fr_q_s[0]         <= '0;
			fr_side_s[0].rmin <= rmin_r5;
			fr_side_s[0].rmax <= rmax_r5;
			fr_side_s[0].rec  <= rec_r5;
			fr_side_s[0].a0   <= a0_r5;
			fr_side_s[0].one  <= one_c;
		end
	end

	for (genvar j = 0; j < 32; j++) begin : g_frac
		logic [37:0] sh;
		logic [37:0] diff;
		logic        ge;
		assign sh   = {fr_rem_s[j], 1'b0};
		assign diff = sh - {1'b0, fr_den_s[j]};
		assign ge   = sh >= {1'b0, fr_den_s[j]};
		always_ff @(posedge clk) begin
			if (en) begin
				fr_rem_s[j+1]  <= ge ? diff[36:0] : sh[36:0];
				fr_den_s[j+1]  <= fr_den_s[j];
				fr_q_s[j+1]    <= {fr_q_s[j][30:0], ge};
				fr_side_s[j+1] <= fr_side_s[j];
			end
		end
	end

	// integer square root, two radicand bits a stage
	logic [31:0]      sq_x_s    [0:16];
	logic [31:0]      sq_res_s  [0:16];
	tal_pkg::tal_rt_t sq_side_s [0:16];

	assign sq_x_s[0]    = fr_q_s[32];
	assign sq_res_s[0]  = '0;
	assign sq_side_s[0] = fr_side_s[32];

	for (genvar j = 0; j < 16; j++) begin : g_sqrt
		logic [31:0] bitv;
		logic [32:0] trial;
		logic        ge;
		assign bitv  = 32'h4000_0000 >> (2 * j);
		assign trial = {1'b0, sq_res_s[j]} + {1'b0, bitv};
		assign ge    = {1'b0, sq_x_s[j]} >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				sq_x_s[j+1]    <= ge ? sq_x_s[j] - trial[31:0] : sq_x_s[j];
				sq_res_s[j+1]  <= ge ? (sq_res_s[j] >> 1) + bitv : sq_res_s[j] >> 1;
				sq_side_s[j+1] <= sq_side_s[j];
			end
		end
	end

	// final stage
	tal_pkg::tal_res_t res_f;
	tal_pkg::tal_res_t out_res;

	always_ff @(posedge clk) begin
		if (en) begin
			res_f.min_radius         <= sq_side_s[16].rmin;
			res_f.max_radius         <= sq_side_s[16].rmax;
			res_f.recommended_radius <= sq_side_s[16].rec;
			if (sq_side_s[16].a0) begin
				res_f.corner_ratio <= tal_pkg::RATIO_DEFAULT;
			end else if (sq_side_s[16].one) begin
				res_f.corner_ratio <= tal_pkg::RATIO_ONE;
			end else begin
				res_f.corner_ratio <= {1'b0, sq_res_s[16][15:0]};
			end
		end
	end

	tal_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_q[tal_pkg::TAL_DEPTH-1]),
		.in_ready (en),
		.in_res   (res_f),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (out_res)
	);

	assign m_axis_tdata = {7'b0, out_res};

	// pipeline only freezes once a result is held and another waits behind it
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result on output");

	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[88:72] <= tal_pkg::RATIO_ONE)
		else $error("corner ratio above one");

	a_min_floor: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:0] >= tal_pkg::RADIUS_FLOOR)
		else $error("minimum radius below floor");

endmodule
`default_nettype wire

/* tb/sv/trochoid_arc_limit_calc_tb.sv */
// ----------------------------------------------------------------------------
// trochoid_arc_limit_calc_tb
// Drives feed, diameter, loop radius factor and engagement items into the calculator
// and checks every result against a behavioral model of the radius limits
// and corner ratio, across several acceleration limits and idle patterns.
// ----------------------------------------------------------------------------
module trochoid_arc_limit_calc_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [16:0] corner_ratio;
		logic [23:0] recommended_radius;
		logic [23:0] max_radius;
		logic [23:0] min_radius;
	} radius_res_t;

	localparam int EXP_DEPTH = 2048;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [16:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;

	logic [16:0] accel = tal_pkg::ACCEL_RESET;
	radius_res_t exp_mem [0:EXP_DEPTH-1];
	int          exp_wr = 0;
	int          exp_rd = 0;
	int          mismatches = 0;
	int          results_seen = 0;
	int          items_sent = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	always #10 clk = ~clk;

	trochoid_arc_limit_calc dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
	);

	function automatic logic [23:0] sat24(logic [63:0] x);
		return (x > 64'hFFFFFF) ? 24'hFFFFFF : x[23:0];
	endfunction

	function automatic logic [15:0] root32(logic [31:0] x);
		logic [15:0] r;
		r = '0;
		for (int b = 15; b >= 0; b--) begin
			logic [15:0] t;
			t = r | (16'd1 << b);
			if ({32'd0, t} * t <= {32'd0, x})
				r = t;
		end
		return r;
	endfunction

	function automatic radius_res_t predict_radii(logic [16:0] f, logic [16:0] d,
			logic [15:0] lf, logic [15:0] me, logic [16:0] a);
		radius_res_t r;
		logic [63:0] phys, tool, rmin, rmax, rec, num, den, q, rem;
		phys = 0;
		if (a != 0)
			phys = sat24((64'd5 * f * f) / (64'd18 * a));
		tool = sat24((64'(lf) * d) >> 14);
		rmin = (phys > tool) ? phys : tool;
		if (rmin < 500)
			rmin = 500;
		rmax = sat24((64'(me) * d * 3) >> 14);
		rec = (13 * rmin + 7 * rmax) / 20;
		if (a == 0) begin
			r.corner_ratio = tal_pkg::RATIO_DEFAULT;
		end else begin
			if (f != 0) begin
				num = 64'd18 * a * rec;
				den = 64'd5 * f * f;
			end else begin
				num = 64'(a) * rec;
				den = 64'd1000000000;
			end
			if (num >= den) begin
				r.corner_ratio = tal_pkg::RATIO_ONE;
			end else begin
				// num < den < 2^37, so shifting fits in 64 bits
				q = 0;
				rem = num;
				for (int i = 0; i < 32; i++) begin
					rem = rem << 1;
					q = q << 1;
					if (rem >= den) begin
						rem -= den;
						q |= 1;
					end
				end
				r.corner_ratio = {1'b0, root32(q[31:0])};
			end
		end
		r.min_radius = rmin[23:0];
		r.max_radius = rmax[23:0];
		r.recommended_radius = rec[23:0];
		return r;
	endfunction

	// tvalid stays high between back-to-back items and drops only while idling
	task automatic send_item(logic [16:0] f, logic [16:0] d, logic [15:0] lf,
			logic [15:0] me);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tdata <= {6'd0, me, lf, d, f};
		s_axis_tvalid <= 1'b1;
		exp_mem[exp_wr % EXP_DEPTH] = predict_radii(f, d, lf, me, accel);
		exp_wr++;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// receiver stall pattern
	always @(posedge clk)
		m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			radius_res_t got, exp_r;
			got = m_axis_tdata[88:0];
			if (exp_wr == exp_rd) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item %h", got);
			end else begin
				exp_r = exp_mem[exp_rd % EXP_DEPTH];
				exp_rd++;
				results_seen++;
				if (got !== exp_r || m_axis_tdata[95:89] !== 7'd0) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp min %0d max %0d rec %0d ratio %0d,",
							" got min %0d max %0d rec %0d ratio %0d"},
							exp_r.min_radius, exp_r.max_radius, exp_r.recommended_radius,
							exp_r.corner_ratio, got.min_radius, got.max_radius,
							got.recommended_radius, got.corner_ratio);
				end
			end
		end
	end

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (exp_wr != exp_rd)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_accel(logic [16:0] v);
		drain();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		accel = v;
	endtask

	task automatic random_item();
		logic [16:0] f, d;
		case ($urandom_range(5))
			0: f = 17'($urandom);
			1: f = 17'($urandom_range(600));
			default: f = 17'($urandom_range(120000));
		endcase
		case ($urandom_range(4))
			0: d = 17'($urandom);
			1: d = 17'($urandom_range(1, 2000));
			default: d = 17'($urandom_range(1, 100000));
		endcase
		send_item(f, d, 16'($urandom),
			16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(16384)));
	endtask

	task automatic test_directed();
		send_item(0, 1, 0, 0);
		send_item(0, 100000, 16384, 16384);
		send_item(120000, 100000, 65535, 65535);
		send_item(17'h1FFFF, 17'h1FFFF, 16'hFFFF, 16'hFFFF);
		send_item(1, 1, 0, 0);
		send_item(6000, 10000, 8192, 4096);
		send_item(60000, 20000, 4000, 16384);
		send_item(17'h1FFFF, 0, 0, 0);
		send_item(600, 50000, 16384, 65535);
		set_accel(0);
		send_item(0, 10000, 8192, 8192);
		send_item(120000, 100000, 65535, 65535);
		send_item(30000, 12000, 100, 5000);
		set_accel(1);
		send_item(120000, 100000, 0, 65535);
		send_item(17'h1FFFF, 1, 0, 0);
		send_item(0, 100000, 65535, 65535);
		set_accel(17'h1FFFF);
		send_item(120000, 6000, 16384, 8192);
		send_item(0, 100000, 65535, 65535);
		send_item(1, 1, 1, 1);
	endtask

	task automatic test_random(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (n) random_item();
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		set_accel(100000);
		test_random(300, 0, 0);
		set_accel(5000);
		test_random(300, 85, 0);
		set_accel(17'($urandom_range(1, 100000)));
		test_random(300, 0, 85);
		set_accel(0);
		test_random(150, 7, 7);
		set_accel(17'($urandom_range(1, 2000)));
		test_random(300, 7, 7);
		drain();
		$display("sent %0d items over several acceleration limits, %0d results checked",
			items_sent, results_seen);
		$display("idle patterns: none, sender 85%%, receiver 85%%, both 7%%");
		if (mismatches == 0 && exp_wr == exp_rd)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule

/* trochoid_arc_limit_calc.f */
hdl/tal_pkg.sv
hdl/tal_out_buf.sv
hdl/trochoid_arc_limit_calc.sv
tb/sv/trochoid_arc_limit_calc_tb.sv
